@@ src/assert_macros.svh @@
// assertion macros for the rtl files; the parser unit is the only one that includes them
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/wrp_pkg.sv @@
// types, tag constants and the sample format classifier for the wav header parser
// no dependencies
package wrp_pkg;

	typedef enum logic [3:0] {
		PH_RIFF  = 4'd0,
		PH_RSIZE = 4'd1,
		PH_WAVE  = 4'd2,
		PH_CHDR  = 4'd3,
		PH_FMT   = 4'd4,
		PH_DATA  = 4'd5,
		PH_SKIP  = 4'd6,
		PH_PAD   = 4'd7,
		PH_HALT  = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_RIFF   = 3'd1,
		ST_NO_WAVE   = 3'd2,
		ST_SHORT_FMT = 3'd3,
		ST_SHORT_BEXT = 3'd4,
		ST_TRUNCATED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		SF_UNKNOWN = 3'd0,
		SF_U8      = 3'd1,
		SF_S16     = 3'd2,
		SF_S24     = 3'd3,
		SF_S32     = 3'd4,
		SF_FLOAT32 = 3'd5,
		SF_FLOAT64 = 3'd6
	} sample_fmt_t;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;
	localparam logic [31:0] TAG_BEXT = 32'h6265_7874;

	localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
	localparam logic [31:0] BEXT_MIN_SIZE = 32'd602;

	localparam logic [15:0] WAVE_FORMAT_PCM   = 16'd1;
	localparam logic [15:0] WAVE_FORMAT_FLOAT = 16'd3;

	// fmt body bytes kept
	localparam int FMT_BYTES = 16;

	function automatic sample_fmt_t classify(input logic [15:0] fmt, input logic [15:0] bits);
		sample_fmt_t c;
		c = SF_UNKNOWN;
		if (fmt == WAVE_FORMAT_PCM) begin
			case (bits)
				16'd8:   c = SF_U8;
				16'd16:  c = SF_S16;
				16'd24:  c = SF_S24;
				16'd32:  c = SF_S32;
				default: c = SF_UNKNOWN;
			endcase
		end else if (fmt == WAVE_FORMAT_FLOAT) begin
			case (bits)
				16'd32:  c = SF_FLOAT32;
				16'd64:  c = SF_FLOAT64;
				default: c = SF_UNKNOWN;
			endcase
		end
		return c;
	endfunction

endpackage

@@ src/wav_riff_header_parser_unit.sv @@
// wav riff header parser: one file byte per transfer in, one result per transfer out
// depends on wrp_pkg and assert_macros.svh
`include "assert_macros.svh"

// channel   dir  tdata                       tuser         tlast
// s_axis    in   byte_in [7:0]               start_req     end_of_file
// m_axis    out  sample_byte .. status [175:0] sample_valid  -
//
// one byte is parsed per cycle while s_axis_tready is high; a result is ready in the cycle after its transfer
// the parser state and the result register update in the cycle of the input transfer
// s_axis_tready is high whenever the result register is empty or being drained
// arst_n puts the parser at the start of the riff tag with all fields zero
// start_req restarts the parser on the byte that carries it

module wav_riff_header_parser_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] byte_in
	input  logic         s_axis_tuser,  // [0] start_req
	input  logic         s_axis_tlast,  // end_of_file
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] sample_byte, [23:8] audio_format, [39:24] channel_count,
	// [71:40] sample_rate, [103:72] byte_rate, [119:104] block_align,
	// [135:120] bits_per_sample, [138:136] sample_format, [170:139] data_size,
	// [173:171] status, [175:174] zero
	output logic [175:0] m_axis_tdata,
	output logic         m_axis_tuser   // [0] sample_valid
);

	// parser state
	wrp_pkg::phase_t      phase_q, phase_d;
	logic [4:0]           idx_q, idx_d;
	logic [31:0]          tag_q, tag_d;
	logic [31:0]          size_q, size_d;
	logic [31:0]          left_q, left_d;
	logic                 pad_q, pad_d;
	logic [127:0]         fmt_q, fmt_d;
	logic [31:0]          dlen_q, dlen_d;
	wrp_pkg::status_t     err_q, err_d;
	wrp_pkg::sample_fmt_t class_q, class_d;
	logic                 sample_d;

	// result register
	logic                 out_valid_q;
	logic                 sample_q;
	logic [175:0]         out_data_q, out_data_d;

	logic                 in_xfer;
	logic [7:0]           b;
	logic [4:0]           idx_inc;
	logic [31:0]          left_dec;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;

	// next parser state for the byte at the input
	always_comb begin
		if (s_axis_tuser) begin
			phase_d = wrp_pkg::PH_RIFF;
			idx_d   = '0;
			tag_d   = '0;
			size_d  = '0;
			left_d  = '0;
			pad_d   = 1'b0;
			fmt_d   = '0;
			dlen_d  = '0;
			err_d   = wrp_pkg::ST_OK;
			class_d = wrp_pkg::SF_UNKNOWN;
		end else begin
			phase_d = phase_q;
			idx_d   = idx_q;
			tag_d   = tag_q;
			size_d  = size_q;
			left_d  = left_q;
			pad_d   = pad_q;
			fmt_d   = fmt_q;
			dlen_d  = dlen_q;
			err_d   = err_q;
			class_d = class_q;
		end
		sample_d = 1'b0;
		idx_inc  = idx_d + 5'd1;
		left_dec = left_d - 32'd1;

		case (phase_d)
			wrp_pkg::PH_RIFF, wrp_pkg::PH_WAVE: begin
				tag_d = {tag_d[23:0], b};
				idx_d = idx_inc;
				if (idx_inc >= 5'd4) begin
					idx_d = '0;
					if (phase_d == wrp_pkg::PH_RIFF) begin
						if (tag_d != wrp_pkg::TAG_RIFF) begin
							err_d   = wrp_pkg::ST_NO_RIFF;
							phase_d = wrp_pkg::PH_HALT;
						end else begin
							phase_d = wrp_pkg::PH_RSIZE;
						end
					end else begin
						if (tag_d != wrp_pkg::TAG_WAVE) begin
							err_d   = wrp_pkg::ST_NO_WAVE;
							phase_d = wrp_pkg::PH_HALT;
						end else begin
							phase_d = wrp_pkg::PH_CHDR;
						end
					end
				end
			end
			wrp_pkg::PH_RSIZE: begin
				idx_d = idx_inc;
				if (idx_inc >= 5'd4) begin
					idx_d   = '0;
					phase_d = wrp_pkg::PH_WAVE;
				end
			end
			wrp_pkg::PH_CHDR: begin
				if (idx_d < 5'd4) begin
					tag_d = {tag_d[23:0], b};
				end else begin
					size_d = {b, size_d[31:8]};
				end
				idx_d = idx_inc;
				if (idx_inc >= 5'd8) begin
					// chunk header complete
					left_d = size_d;
					pad_d  = size_d[0];
					idx_d  = '0;
					if (tag_d == wrp_pkg::TAG_FMT) begin
						phase_d = wrp_pkg::PH_FMT;
					end else if (tag_d == wrp_pkg::TAG_DATA) begin
						dlen_d  = size_d;
						phase_d = wrp_pkg::PH_DATA;
					end else begin
						phase_d = wrp_pkg::PH_SKIP;
					end
					if (size_d == '0) begin
						phase_d = wrp_pkg::PH_CHDR;
					end
					if (tag_d == wrp_pkg::TAG_FMT && size_d < wrp_pkg::FMT_MIN_SIZE) begin
						err_d   = wrp_pkg::ST_SHORT_FMT;
						phase_d = wrp_pkg::PH_HALT;
					end
					if (tag_d == wrp_pkg::TAG_BEXT && size_d < wrp_pkg::BEXT_MIN_SIZE) begin
						err_d   = wrp_pkg::ST_SHORT_BEXT;
						phase_d = wrp_pkg::PH_HALT;
					end
				end
			end
			wrp_pkg::PH_FMT, wrp_pkg::PH_DATA, wrp_pkg::PH_SKIP: begin
				if (phase_d == wrp_pkg::PH_FMT && idx_d < 5'(wrp_pkg::FMT_BYTES)) begin
					fmt_d[idx_d[3:0]*8 +: 8] = b;
					idx_d = idx_inc;
					if (idx_inc == 5'(wrp_pkg::FMT_BYTES)) begin
						class_d = wrp_pkg::classify(fmt_d[15:0], fmt_d[127:112]);
					end
				end
				if (phase_d == wrp_pkg::PH_DATA) begin
					sample_d = 1'b1;
				end
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = pad_d ? wrp_pkg::PH_PAD : wrp_pkg::PH_CHDR;
					pad_d   = 1'b0;
				end
			end
			wrp_pkg::PH_PAD: begin
				phase_d = wrp_pkg::PH_CHDR;
			end
			default: begin
			end
		endcase

		// end of file halts; a stream cut inside the riff or wave header or inside a chunk body is an error
		if (s_axis_tlast && phase_d != wrp_pkg::PH_HALT) begin
			if (phase_d == wrp_pkg::PH_RIFF) begin
				err_d = wrp_pkg::ST_NO_RIFF;
			end else if (phase_d == wrp_pkg::PH_RSIZE || phase_d == wrp_pkg::PH_WAVE) begin
				err_d = wrp_pkg::ST_NO_WAVE;
			end else if (phase_d == wrp_pkg::PH_FMT || phase_d == wrp_pkg::PH_DATA ||
					phase_d == wrp_pkg::PH_SKIP) begin
				err_d = wrp_pkg::ST_TRUNCATED;
			end
			phase_d = wrp_pkg::PH_HALT;
		end
	end

	// result packing
	always_comb begin
		out_data_d = {
			2'b00,
			err_d,
			dlen_d,
			class_d,
			fmt_d[127:112],
			fmt_d[111:96],
			fmt_d[95:64],
			fmt_d[63:32],
			fmt_d[31:16],
			fmt_d[15:0],
			(sample_d ? b : 8'h00)
		};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wrp_pkg::PH_RIFF;
			idx_q   <= '0;
			tag_q   <= '0;
			size_q  <= '0;
			left_q  <= '0;
			pad_q   <= 1'b0;
			fmt_q   <= '0;
			dlen_q  <= '0;
			err_q   <= wrp_pkg::ST_OK;
			class_q <= wrp_pkg::SF_UNKNOWN;
		end else if (in_xfer) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			tag_q   <= tag_d;
			size_q  <= size_d;
			left_q  <= left_d;
			pad_q   <= pad_d;
			fmt_q   <= fmt_d;
			dlen_q  <= dlen_d;
			err_q   <= err_d;
			class_q <= class_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q   <= sample_d;
			out_data_q <= out_data_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = sample_q;
	assign m_axis_tdata  = out_data_q;

	`ASSERT_CLK(a_error_halts, err_q != wrp_pkg::ST_OK |-> phase_q == wrp_pkg::PH_HALT,
		"error reported while parser still running")
	`ASSERT_CLK(a_body_has_bytes, (phase_q == wrp_pkg::PH_FMT || phase_q == wrp_pkg::PH_DATA ||
		phase_q == wrp_pkg::PH_SKIP) |-> left_q != '0, "body phase with no bytes left")
	`ASSERT_CLK(a_fmt_offset, phase_q == wrp_pkg::PH_FMT |-> idx_q <= 5'(wrp_pkg::FMT_BYTES),
		"fmt body offset out of range")
	`ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
		$stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

endmodule
